FILE: hdl/tmu_pkg.sv
// Package for the triangle measure unit: widths, fixed-point constants and item types.
// No dependencies. Every module of the block imports it.
package tmu_pkg;

  localparam int FRAC_BITS = 8;

  localparam int COORD_W = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int D2_W    = PROD_W;
  localparam int CR_W    = PROD_W + 1;
  localparam int ACR_W   = PROD_W;

  localparam int ROOT_W  = D2_W / 2 + FRAC_BITS + 1;
  localparam int REM_W   = ROOT_W + 3;
  localparam int SQ_X_W  = 2 * ROOT_W;

  localparam int SIDE_W  = 25;
  localparam int PERIM_W = 27;
  localparam int AREA_W  = 39;
  localparam int AREA_SH = FRAC_BITS - 1;

  localparam int QUO_W   = SIDE_W + 1;
  localparam int NUM_W   = ACR_W + 2 * FRAC_BITS + 1;
  localparam int HI_W    = NUM_W - QUO_W;

  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QUO_W + 1;
  localparam int ACR_DLY  = SQRT_LAT - 1;
  localparam int PASS_DLY = DIV_LAT;
  localparam int PIPE_LEN = 3 + SQRT_LAT + 1 + DIV_LAT;

  localparam logic [SIDE_W-1:0] SIDE_MAX = '1;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic [COORD_W-1:0] c_y;
    logic [COORD_W-1:0] c_x;
    logic [COORD_W-1:0] b_y;
    logic [COORD_W-1:0] b_x;
    logic [COORD_W-1:0] a_y;
    logic [COORD_W-1:0] a_x;
  } tmu_in_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  height_to_c;
    logic [SIDE_W-1:0]  height_to_b;
    logic [SIDE_W-1:0]  height_to_a;
    logic [AREA_W-1:0]  tri_area;
    logic [PERIM_W-1:0] perim;
    logic [SIDE_W-1:0]  side_c;
    logic [SIDE_W-1:0]  side_b;
    logic [SIDE_W-1:0]  side_a;
  } tmu_out_t;

  typedef struct packed {
    logic               degen;
    logic [AREA_W-1:0]  tri_area;
    logic [PERIM_W-1:0] perim;
    logic [SIDE_W-1:0]  side_c;
    logic [SIDE_W-1:0]  side_b;
    logic [SIDE_W-1:0]  side_a;
  } tmu_pass_t;

  localparam int IN_DATA_W  = $bits(tmu_in_t);
  localparam int OUT_DATA_W = $bits(tmu_out_t);

endpackage

FILE: hdl/tmu_isqrt.sv
// Pipelined digit-by-digit square root, one result bit per register stage.
// Depends on tmu_pkg. Used by triangle_measure_unit for the side lengths.
module tmu_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tmu_pkg::D2_W-1:0]   d2,
  output logic [tmu_pkg::ROOT_W-1:0] root
);
  import tmu_pkg::*;

  logic [REM_W-1:0]  rem_r  [ROOT_W-1];
  logic [SQ_X_W-1:0] x_r    [ROOT_W-1];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  logic [REM_W-1:0]  rem_i  [ROOT_W];
  logic [SQ_X_W-1:0] x_i    [ROOT_W];
  logic [ROOT_W-1:0] root_i [ROOT_W];

  assign rem_i[0]  = '0;
  assign root_i[0] = '0;
  assign x_i[0]    = {d2, {(SQ_X_W - D2_W){1'b0}}};

  genvar s;
  generate
    for (s = 0; s < ROOT_W; s++) begin : g_stage
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (s > 0) begin : g_link
        assign rem_i[s]  = rem_r[s-1];
        assign root_i[s] = root_r[s-1];
        assign x_i[s]    = x_r[s-1];
      end

      assign rem_sh = {rem_i[s][REM_W-3:0], x_i[s][SQ_X_W-1 -: 2]};
      assign trial  = {{(REM_W - ROOT_W - 2){1'b0}}, root_i[s], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[s] <= {root_i[s][ROOT_W-2:0], ge};
        end
      end

      if (s < ROOT_W - 1) begin : g_carry
        logic [REM_W-1:0] rem_nxt;
        assign rem_nxt = ge ? rem_sh - trial : rem_sh;
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s] <= rem_nxt;
            x_r[s]   <= {x_i[s][SQ_X_W-3:0], 2'b00};
          end
        end
      end
    end
  endgenerate

  assign root = root_r[ROOT_W-1];

endmodule

FILE: hdl/tmu_div.sv
// Pipelined restoring divider for the heights: quotient of the scaled cross product by a side.
// Depends on tmu_pkg. One quotient bit per stage after an overflow-check stage.
module tmu_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tmu_pkg::ACR_W-1:0]  num,
  input  logic [tmu_pkg::SIDE_W-1:0] den,
  output logic [tmu_pkg::QUO_W-1:0]  quo,
  output logic                      ovf
);
  import tmu_pkg::*;

  logic [NUM_W-1:0]       n_full;
  logic [HI_W+SIDE_W-1:0] hi_ext;
  logic [HI_W+SIDE_W-1:0] den_ext;

  logic [SIDE_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0]  lo_r  [QUO_W];
  logic [SIDE_W-1:0] den_r [QUO_W];
  logic              ovf_r [QUO_W+1];
  logic [QUO_W-1:0]  q_r   [QUO_W];
  logic [QUO_W-1:0]  q_i   [QUO_W];

  assign n_full  = {num, {(2 * FRAC_BITS + 1){1'b0}}};
  assign hi_ext  = {{SIDE_W{1'b0}}, n_full[NUM_W-1:QUO_W]};
  assign den_ext = {{HI_W{1'b0}}, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[SIDE_W-1:0];
      lo_r[0]  <= n_full[QUO_W-1:0];
      den_r[0] <= den;
      ovf_r[0] <= hi_ext >= den_ext;
    end
  end

  assign q_i[0] = '0;

  genvar s;
  generate
    for (s = 0; s < QUO_W; s++) begin : g_step
      logic [SIDE_W:0] rem2;
      logic            ge;

      if (s > 0) begin : g_link
        assign q_i[s] = q_r[s-1];
      end

      assign rem2 = {rem_r[s], lo_r[s][QUO_W-1]};
      assign ge   = rem2 >= {1'b0, den_r[s]};

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[s]     <= {q_i[s][QUO_W-2:0], ge};
          ovf_r[s+1] <= ovf_r[s];
        end
      end

      if (s < QUO_W - 1) begin : g_carry
        logic [SIDE_W:0] diff;
        assign diff = rem2 - {1'b0, den_r[s]};
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s+1] <= ge ? diff[SIDE_W-1:0] : rem2[SIDE_W-1:0];
            lo_r[s+1]  <= {lo_r[s][QUO_W-2:0], 1'b0};
            den_r[s+1] <= den_r[s];
          end
        end
      end
    end
  endgenerate

  assign quo = q_r[QUO_W-1];
  assign ovf = ovf_r[QUO_W];

endmodule

FILE: hdl/triangle_measure_unit.sv
// Triangle measure unit: sides, perimeter, area and heights of one triangle per item.
// Throughput: one item per cycle while the skid stage is empty; a full skid stage stalls input.
// Rate is set by the fully pipelined square-root (26 stages) and divider (27 stages) lanes.
// An output register with a skid stage lets input flow while one result waits at the output.
// Reset (rst_n low, synchronous) clears the valid bits only; nothing is kept between items.
// Depends on tmu_pkg, tmu_isqrt and tmu_div.
module triangle_measure_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y
  input  logic [tmu_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // side_a, side_b, side_c, perim, tri_area, height_to_a, height_to_b, height_to_c
  output logic [tmu_pkg::OUT_DATA_W-1:0]   out_tdata,
  // degenerate
  output logic                             out_tuser
);
  import tmu_pkg::*;

  function automatic logic [SIDE_W-1:0] round_side(input logic [ROOT_W-1:0] rt);
    logic [ROOT_W:0]        inc;
    logic [ROOT_W+SIDE_W-1:0] ext;
    inc = {1'b0, rt} + {{ROOT_W{1'b0}}, 1'b1};
    ext = {{SIDE_W{1'b0}}, inc[ROOT_W:1]};
    if (ext > {{ROOT_W{1'b0}}, SIDE_MAX}) begin
      return SIDE_MAX;
    end
    return ext[SIDE_W-1:0];
  endfunction

  function automatic logic [SIDE_W-1:0] round_height(input logic [QUO_W-1:0] q,
                                                     input logic ov);
    logic [QUO_W:0] inc;
    inc = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
    if (ov || inc[QUO_W]) begin
      return SIDE_MAX;
    end
    return inc[SIDE_W:1];
  endfunction

  tmu_in_t  in_item;
  logic     en;
  logic     inc_v;
  logic [PIPE_LEN-1:0] vld_r;

  assign in_item   = tmu_in_t'(in_tdata);
  assign in_tready = en;

  // P1: edge deltas
  logic signed [DELTA_W-1:0] dbc_x_r, dbc_y_r, dca_x_r, dca_y_r;
  logic signed [DELTA_W-1:0] dab_x_r, dab_y_r, dac_x_r, dac_y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dbc_x_r <= {in_item.c_x[COORD_W-1], in_item.c_x} - {in_item.b_x[COORD_W-1], in_item.b_x};
      dbc_y_r <= {in_item.c_y[COORD_W-1], in_item.c_y} - {in_item.b_y[COORD_W-1], in_item.b_y};
      dca_x_r <= {in_item.a_x[COORD_W-1], in_item.a_x} - {in_item.c_x[COORD_W-1], in_item.c_x};
      dca_y_r <= {in_item.a_y[COORD_W-1], in_item.a_y} - {in_item.c_y[COORD_W-1], in_item.c_y};
      dab_x_r <= {in_item.b_x[COORD_W-1], in_item.b_x} - {in_item.a_x[COORD_W-1], in_item.a_x};
      dab_y_r <= {in_item.b_y[COORD_W-1], in_item.b_y} - {in_item.a_y[COORD_W-1], in_item.a_y};
      dac_x_r <= {in_item.c_x[COORD_W-1], in_item.c_x} - {in_item.a_x[COORD_W-1], in_item.a_x};
      dac_y_r <= {in_item.c_y[COORD_W-1], in_item.c_y} - {in_item.a_y[COORD_W-1], in_item.a_y};
    end
  end

  // P2: squares and cross terms
  logic signed [PROD_W-1:0] sq_ax_r, sq_ay_r, sq_bx_r, sq_by_r, sq_cx_r, sq_cy_r;
  logic signed [PROD_W-1:0] cp1_r, cp2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ax_r <= dbc_x_r * dbc_x_r;
      sq_ay_r <= dbc_y_r * dbc_y_r;
      sq_bx_r <= dca_x_r * dca_x_r;
      sq_by_r <= dca_y_r * dca_y_r;
      sq_cx_r <= dab_x_r * dab_x_r;
      sq_cy_r <= dab_y_r * dab_y_r;
      cp1_r   <= dab_x_r * dac_y_r;
      cp2_r   <= dab_y_r * dac_x_r;
    end
  end

  // P3: squared distances and cross product
  logic [D2_W-1:0] d2_a_r, d2_b_r, d2_c_r;
  logic [CR_W-1:0] cr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_a_r <= {1'b0, sq_ax_r[PROD_W-2:0]} + {1'b0, sq_ay_r[PROD_W-2:0]};
      d2_b_r <= {1'b0, sq_bx_r[PROD_W-2:0]} + {1'b0, sq_by_r[PROD_W-2:0]};
      d2_c_r <= {1'b0, sq_cx_r[PROD_W-2:0]} + {1'b0, sq_cy_r[PROD_W-2:0]};
      cr_r   <= {cp1_r[PROD_W-1], cp1_r} - {cp2_r[PROD_W-1], cp2_r};
    end
  end

  // P4: magnitude of cross product, zero-side flag
  logic [CR_W-1:0]  cr_neg;
  logic [ACR_W-1:0] acr_r;
  logic             degen_r;

  assign cr_neg = -cr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acr_r   <= cr_r[CR_W-1] ? cr_neg[ACR_W-1:0] : cr_r[ACR_W-1:0];
      degen_r <= (d2_a_r == '0) || (d2_b_r == '0) || (d2_c_r == '0);
    end
  end

  // P4..P29: square roots, with cross product and flag delayed alongside
  logic [ROOT_W-1:0] root_a, root_b, root_c;

  tmu_isqrt u_sqrt_a (.clk(clk), .en(en), .d2(d2_a_r), .root(root_a));
  tmu_isqrt u_sqrt_b (.clk(clk), .en(en), .d2(d2_b_r), .root(root_b));
  tmu_isqrt u_sqrt_c (.clk(clk), .en(en), .d2(d2_c_r), .root(root_c));

  logic [ACR_W-1:0] acr_d_r [ACR_DLY];
  logic             deg_d_r [ACR_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      acr_d_r[0] <= acr_r;
      deg_d_r[0] <= degen_r;
      for (int i = 1; i < ACR_DLY; i++) begin
        acr_d_r[i] <= acr_d_r[i-1];
        deg_d_r[i] <= deg_d_r[i-1];
      end
    end
  end

  // P30: rounded sides and area
  logic [SIDE_W-1:0] side_a_r, side_b_r, side_c_r;
  logic [ACR_W-1:0]  acr30_r;
  logic [AREA_W-1:0] area30_r;
  logic              deg30_r;
  logic [ACR_W+AREA_SH+AREA_W-1:0] area_ext;

  assign area_ext = {{AREA_W{1'b0}}, acr_d_r[ACR_DLY-1], {AREA_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r <= round_side(root_a);
      side_b_r <= round_side(root_b);
      side_c_r <= round_side(root_c);
      acr30_r  <= acr_d_r[ACR_DLY-1];
      deg30_r  <= deg_d_r[ACR_DLY-1];
      area30_r <= (area_ext > {{(ACR_W + AREA_SH){1'b0}}, AREA_MAX}) ?
                  AREA_MAX : area_ext[AREA_W-1:0];
    end
  end

  // P31..P57: heights, with the other results delayed alongside
  logic [QUO_W-1:0] quo_a, quo_b, quo_c;
  logic             ovf_a, ovf_b, ovf_c;

  tmu_div u_div_a (.clk(clk), .en(en), .num(acr30_r), .den(side_a_r), .quo(quo_a), .ovf(ovf_a));
  tmu_div u_div_b (.clk(clk), .en(en), .num(acr30_r), .den(side_b_r), .quo(quo_b), .ovf(ovf_b));
  tmu_div u_div_c (.clk(clk), .en(en), .num(acr30_r), .den(side_c_r), .quo(quo_c), .ovf(ovf_c));

  tmu_pass_t pt_d_r [PASS_DLY];
  tmu_pass_t pt_nxt;

  always_comb begin
    pt_nxt.side_a   = side_a_r;
    pt_nxt.side_b   = side_b_r;
    pt_nxt.side_c   = side_c_r;
    pt_nxt.perim    = {2'b00, side_a_r} + {2'b00, side_b_r} + {2'b00, side_c_r};
    pt_nxt.tri_area = area30_r;
    pt_nxt.degen    = deg30_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_d_r[0] <= pt_nxt;
      for (int i = 1; i < PASS_DLY; i++) begin
        pt_d_r[i] <= pt_d_r[i-1];
      end
    end
  end

  // final rounding, degenerate forcing
  tmu_pass_t pt_last;
  tmu_out_t  res;

  assign pt_last = pt_d_r[PASS_DLY-1];

  always_comb begin
    res.side_a      = pt_last.side_a;
    res.side_b      = pt_last.side_b;
    res.side_c      = pt_last.side_c;
    res.perim       = pt_last.perim;
    res.tri_area    = pt_last.tri_area;
    res.height_to_a = pt_last.degen ? '0 : round_height(quo_a, ovf_a);
    res.height_to_b = pt_last.degen ? '0 : round_height(quo_b, ovf_b);
    res.height_to_c = pt_last.degen ? '0 : round_height(quo_c, ovf_c);
  end

  // valid bits, output register and skid stage
  logic     out_valid_r, skid_v_r;
  tmu_out_t out_data_r, skid_data_r;
  logic     out_deg_r, skid_deg_r;
  logic     take;

  assign en    = !skid_v_r;
  assign inc_v = en && vld_r[PIPE_LEN-1];
  assign take  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[PIPE_LEN-2:0], in_tvalid};
      end
      if (take) begin
        out_valid_r <= skid_v_r || inc_v;
        skid_v_r    <= 1'b0;
      end else if (inc_v) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= skid_v_r ? skid_data_r : res;
      out_deg_r  <= skid_v_r ? skid_deg_r : pt_last.degen;
    end else if (inc_v) begin
      skid_data_r <= res;
      skid_deg_r  <= pt_last.degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  a_degen_heights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_data_r.height_to_a == '0 &&
      out_data_r.height_to_b == '0 && out_data_r.height_to_c == '0))
    else $error("degenerate triangle with a nonzero height");

  a_degen_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_data_r.tri_area == '0))
    else $error("degenerate triangle with a nonzero area");

endmodule
